// ===== rtl/pbvt_pkg.sv =====
// shared types for the primary/backup view tracker
`timescale 1ns / 1ps

package pbvt_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DROP,
      ST_DROP_TAIL,
      ST_REFILL_START,
      ST_REFILL_SCAN,
      ST_REFILL_FIN,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;        // capture request and role snapshot
      logic ping_apply;    // record ping for the captured replica
      logic tick_inc;      // advance the saturating tick count
      logic cnt_clear;     // restart the slot counter
      logic cnt_inc;       // step the slot counter
      logic drop_issue;    // read last-heard for the current slot
      logic refill_start;  // promote backup into an empty primary role
      logic refill_step;   // examine the live bit of the current slot
      logic refill_fin;    // commit refill candidates
      logic publish;       // bump view if roles changed, load response
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_tick;
      logic cnt_last;
      logic out_busy;
   } status_type;

endpackage

// ===== rtl/primary_backup_view_tracker.sv =====
// top level of the primary/backup view tracker
`timescale 1ns / 1ps

// Heartbeat-driven primary/backup selector for up to MAX_REPLICAS numbered
// replicas. A request is either a ping (req_action 0) from req_replica_id or
// one time tick (req_action 1); every request yields exactly one response
// with the view number, both roles and the tick count after it. A tick walks the
// last-heard memory one slot per cycle through its single registered read
// port to drop silent replicas, then every request walks the live mask one
// slot per cycle to pick the lowest live replicas for empty roles. The
// response sits in an output register, so a new request is taken while the
// previous response is still waiting. The silence timeout, in ticks, is
// written through csr_we/csr_wdata and must only change while no request is
// in flight. The last-heard memory needs no clearing after reset since only
// the entries of live replicas are ever used.

module primary_backup_view_tracker #(
   parameter int MAX_REPLICAS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic [3:0]  req_replica_id,
   input  logic [31:0] req_client_view,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_view_number,
   output logic        rsp_primary_valid,
   output logic [3:0]  rsp_primary_id,
   output logic        rsp_backup_valid,
   output logic [3:0]  rsp_backup_id,
   output logic [31:0] rsp_time_now,
   // silence timeout register
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   pbvt_pkg::cmd_type    cmd;
   pbvt_pkg::status_type status;

   // sequencer: accept, apply ping or tick, drop scan on a tick, refill scan, publish
   pbvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // replica state, role registers and the response register
   pbvt_dpath #(
      .MAX_REPLICAS (MAX_REPLICAS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_action        (req_action),
      .req_replica_id    (req_replica_id),
      .req_client_view   (req_client_view),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_view_number   (rsp_view_number),
      .rsp_primary_valid (rsp_primary_valid),
      .rsp_primary_id    (rsp_primary_id),
      .rsp_backup_valid  (rsp_backup_valid),
      .rsp_backup_id     (rsp_backup_id),
      .rsp_time_now      (rsp_time_now)
   );

endmodule

// ===== rtl/pbvt_ctrl.sv =====
// sequencing state machine for the primary/backup view tracker
`timescale 1ns / 1ps

module pbvt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pbvt_pkg::status_type status,
   output pbvt_pkg::cmd_type    cmd
);

   pbvt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbvt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         pbvt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = pbvt_pkg::ST_EXEC;
            end
         end
         pbvt_pkg::ST_EXEC: begin
            if (status.is_tick) begin
               cmd.tick_inc  = 1'b1;
               cmd.cnt_clear = 1'b1;
               state_in      = pbvt_pkg::ST_DROP;
            end else begin
               cmd.ping_apply = 1'b1;
               state_in       = pbvt_pkg::ST_REFILL_START;
            end
         end
         pbvt_pkg::ST_DROP: begin
            cmd.drop_issue = 1'b1;
            cmd.cnt_inc    = 1'b1;
            if (status.cnt_last) begin
               state_in = pbvt_pkg::ST_DROP_TAIL;
            end
         end
         pbvt_pkg::ST_DROP_TAIL: begin
            // last slot compare lands here
            state_in = pbvt_pkg::ST_REFILL_START;
         end
         pbvt_pkg::ST_REFILL_START: begin
            cmd.refill_start = 1'b1;
            cmd.cnt_clear    = 1'b1;
            state_in         = pbvt_pkg::ST_REFILL_SCAN;
         end
         pbvt_pkg::ST_REFILL_SCAN: begin
            cmd.refill_step = 1'b1;
            cmd.cnt_inc     = 1'b1;
            if (status.cnt_last) begin
               state_in = pbvt_pkg::ST_REFILL_FIN;
            end
         end
         pbvt_pkg::ST_REFILL_FIN: begin
            cmd.refill_fin = 1'b1;
            state_in       = pbvt_pkg::ST_FINISH;
         end
         pbvt_pkg::ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.publish = 1'b1;
               state_in    = pbvt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pbvt_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/pbvt_dpath.sv =====
// replica state, last-heard memory, role registers and response register
`timescale 1ns / 1ps

module pbvt_dpath #(
   parameter int MAX_REPLICAS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pbvt_pkg::cmd_type    cmd,
   output pbvt_pkg::status_type status,
   input  logic                 req_action,
   input  logic [3:0]           req_replica_id,
   input  logic [31:0]          req_client_view,
   input  logic                 csr_we,
   input  logic [15:0]          csr_wdata,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_view_number,
   output logic                 rsp_primary_valid,
   output logic [3:0]           rsp_primary_id,
   output logic                 rsp_backup_valid,
   output logic [3:0]           rsp_backup_id,
   output logic [31:0]          rsp_time_now
);

   localparam int IDX_W = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_REPLICAS - 1);

   // last-heard memory, only ever compared for live replicas
   logic [31:0] heard_mem [MAX_REPLICAS];
   logic [31:0] heard_rd_ff;

   logic [MAX_REPLICAS-1:0] live_ff, live_in;
   logic [31:0]      tick_ff, tick_in;
   logic [31:0]      view_ff, view_in;
   logic             hp_ff, hp_in, hb_ff, hb_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in, bidx_ff, bidx_in;
   logic [15:0]      dead_ff;

   logic             act_ff;
   logic [3:0]       id_ff;
   logic [31:0]      cview_ff;
   logic             pv0_ff, bv0_ff;
   logic [IDX_W-1:0] pi0_ff, bi0_ff;

   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             chk_v_ff;
   logic [IDX_W-1:0] chk_idx_ff;

   logic             f1v_ff, f1v_in, f2v_ff, f2v_in, fxv_ff, fxv_in;
   logic [IDX_W-1:0] f1_ff, f1_in, f2_ff, f2_in, fx_ff, fx_in;

   logic             rv_ff, rv_in;
   logic [31:0]      r_view_ff, r_time_ff;
   logic             r_pv_ff, r_bv_ff;
   logic [3:0]       r_pid_ff, r_bid_ff;

   logic [IDX_W-1:0] ping_idx;
   logic             ping_ok;
   logic             expired;
   logic             roles_changed;

   assign ping_idx = IDX_W'(id_ff);
   assign ping_ok  = 8'(id_ff) < 8'(MAX_REPLICAS);
   assign expired  = {1'b0, tick_ff} >= ({1'b0, heard_rd_ff} + {17'b0, dead_ff});
   assign roles_changed = (pv0_ff != hp_ff) || (pv0_ff && hp_ff && pi0_ff != pidx_ff) ||
                          (bv0_ff != hb_ff) || (bv0_ff && hb_ff && bi0_ff != bidx_ff);

   assign status.is_tick  = act_ff;
   assign status.cnt_last = cnt_ff == LAST_SLOT;
   assign status.out_busy = rv_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.ping_apply && ping_ok) begin
         heard_mem[ping_idx] <= tick_ff;
      end
      heard_rd_ff <= heard_mem[cnt_ff];
   end

   always_comb begin
      live_in = live_ff;
      tick_in = tick_ff;
      view_in = view_ff;
      hp_in   = hp_ff;
      pidx_in = pidx_ff;
      hb_in   = hb_ff;
      bidx_in = bidx_ff;
      cnt_in  = cnt_ff;
      f1v_in  = f1v_ff;
      f1_in   = f1_ff;
      f2v_in  = f2v_ff;
      f2_in   = f2_ff;
      fxv_in  = fxv_ff;
      fx_in   = fx_ff;
      rv_in   = rv_ff && !rsp_ready;

      if (cmd.cnt_clear) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc && cnt_ff != LAST_SLOT) begin
         cnt_in = cnt_ff + 1'b1;
      end

      if (cmd.ping_apply && ping_ok) begin
         live_in[ping_idx] = 1'b1;
         // restarted primary gives up its role
         if (hp_ff && pidx_ff == ping_idx && cview_ff == 32'd0) begin
            hp_in   = 1'b0;
            pidx_in = '0;
         end
      end

      if (cmd.tick_inc && tick_ff != 32'hFFFF_FFFF) begin
         tick_in = tick_ff + 32'd1;
      end

      if (chk_v_ff && live_ff[chk_idx_ff] && expired) begin
         live_in[chk_idx_ff] = 1'b0;
         if (hp_ff && pidx_ff == chk_idx_ff) begin
            hp_in   = 1'b0;
            pidx_in = '0;
         end
         if (hb_ff && bidx_ff == chk_idx_ff) begin
            hb_in   = 1'b0;
            bidx_in = '0;
         end
      end

      if (cmd.refill_start) begin
         f1v_in = 1'b0;
         f2v_in = 1'b0;
         fxv_in = 1'b0;
         if (!hp_ff && hb_ff) begin
            hp_in   = 1'b1;
            pidx_in = bidx_ff;
            hb_in   = 1'b0;
            bidx_in = '0;
         end
      end

      if (cmd.refill_step && live_ff[cnt_ff]) begin
         if (!f1v_ff) begin
            f1v_in = 1'b1;
            f1_in  = cnt_ff;
         end else if (!f2v_ff) begin
            f2v_in = 1'b1;
            f2_in  = cnt_ff;
         end
         if (!fxv_ff && cnt_ff != pidx_ff) begin
            fxv_in = 1'b1;
            fx_in  = cnt_ff;
         end
      end

      if (cmd.refill_fin) begin
         if (!hp_ff) begin
            // no primary means no backup either after promotion
            hp_in   = f1v_ff;
            pidx_in = f1v_ff ? f1_ff : '0;
            hb_in   = f2v_ff;
            bidx_in = f2v_ff ? f2_ff : '0;
         end else if (!hb_ff) begin
            hb_in   = fxv_ff;
            bidx_in = fxv_ff ? fx_ff : '0;
         end
      end

      if (cmd.publish) begin
         rv_in   = 1'b1;
         view_in = view_ff + 32'(roles_changed);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff  <= '0;
         tick_ff  <= '0;
         view_ff  <= '0;
         hp_ff    <= 1'b0;
         pidx_ff  <= '0;
         hb_ff    <= 1'b0;
         bidx_ff  <= '0;
         dead_ff  <= 16'd5;
         cnt_ff   <= '0;
         chk_v_ff <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         live_ff  <= live_in;
         tick_ff  <= tick_in;
         view_ff  <= view_in;
         hp_ff    <= hp_in;
         pidx_ff  <= pidx_in;
         hb_ff    <= hb_in;
         bidx_ff  <= bidx_in;
         cnt_ff   <= cnt_in;
         chk_v_ff <= cmd.drop_issue;
         rv_ff    <= rv_in;
         if (csr_we) begin
            dead_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      chk_idx_ff <= cnt_ff;
      f1v_ff     <= f1v_in;
      f1_ff      <= f1_in;
      f2v_ff     <= f2v_in;
      f2_ff      <= f2_in;
      fxv_ff     <= fxv_in;
      fx_ff      <= fx_in;
      if (cmd.accept) begin
         act_ff   <= req_action;
         id_ff    <= req_replica_id;
         cview_ff <= req_client_view;
         pv0_ff   <= hp_ff;
         pi0_ff   <= pidx_ff;
         bv0_ff   <= hb_ff;
         bi0_ff   <= bidx_ff;
      end
      if (cmd.publish) begin
         r_view_ff <= view_in;
         r_time_ff <= tick_ff;
         r_pv_ff   <= hp_ff;
         r_pid_ff  <= hp_ff ? 4'(pidx_ff) : 4'd0;
         r_bv_ff   <= hb_ff;
         r_bid_ff  <= hb_ff ? 4'(bidx_ff) : 4'd0;
      end
   end

   assign rsp_valid         = rv_ff;
   assign rsp_view_number   = r_view_ff;
   assign rsp_primary_valid = r_pv_ff;
   assign rsp_primary_id    = r_pid_ff;
   assign rsp_backup_valid  = r_bv_ff;
   assign rsp_backup_id     = r_bid_ff;
   assign rsp_time_now      = r_time_ff;

endmodule

// ===== rtl/pbvt_checker.sv =====
// port-level assertions for the primary/backup view tracker, with bind
`timescale 1ns / 1ps

module pbvt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_view_number,
   input logic        rsp_primary_valid,
   input logic [3:0]  rsp_primary_id,
   input logic        rsp_backup_valid,
   input logic [3:0]  rsp_backup_id
);

   // one request at a time: ready drops right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_view_number))
      else $error("stalled response changed");

   // unassigned roles report index zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_primary_valid || rsp_primary_id == 4'd0) &&
                    (rsp_backup_valid || rsp_backup_id == 4'd0))
      else $error("unassigned role carries an index");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_primary_valid && rsp_backup_valid |->
         rsp_primary_id != rsp_backup_id)
      else $error("primary and backup are the same replica");

   // a backup never stands without a primary
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_backup_valid |-> rsp_primary_valid)
      else $error("backup assigned without primary");

endmodule

bind primary_backup_view_tracker pbvt_checker u_pbvt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_view_number   (rsp_view_number),
   .rsp_primary_valid (rsp_primary_valid),
   .rsp_primary_id    (rsp_primary_id),
   .rsp_backup_valid  (rsp_backup_valid),
   .rsp_backup_id     (rsp_backup_id)
);
